@@ rtl/pwbs_pkg.sv @@
package pwbs_pkg;

    // Field widths
    localparam int unsigned IDX_W   = 6;
    localparam int unsigned POS_W   = 19;
    localparam int unsigned VEL_W   = 16;
    localparam int unsigned AREA_W  = 11;
    localparam int unsigned RAD_W   = 16;
    localparam int unsigned DT_W    = 12;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // Store geometry
    localparam int unsigned MAX_PARTICLES_DEF = 64;
    localparam int unsigned POS_MEM_W = 2 * POS_W;
    localparam int unsigned VEL_MEM_W = 2 * VEL_W;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_AREA_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AREA_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GRAVITY     = 3'd4;

    // Register reset values
    localparam logic [AREA_W-1:0]       AREA_WIDTH_RST  = 11'd800;
    localparam logic [AREA_W-1:0]       AREA_HEIGHT_RST = 11'd800;
    localparam logic [RAD_W-1:0]        RADIUS_RST      = 16'd1280;
    localparam logic [DT_W-1:0]         TIME_STEP_RST   = 12'd256;
    localparam logic signed [VEL_W-1:0] GRAVITY_RST     = -16'sd2509;

    // Velocity range
    localparam logic signed [VEL_W-1:0] VEL_MAX = 16'sh7FFF;
    localparam logic signed [VEL_W-1:0] VEL_MIN = 16'sh8000;

    // Function codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_STEP = 1'b1;

    typedef struct packed {
        logic [AREA_W-1:0]       area_width;
        logic [AREA_W-1:0]       area_height;
        logic [RAD_W-1:0]        radius;
        logic [DT_W-1:0]         time_step;
        logic signed [VEL_W-1:0] gravity;
    } cfg_t;

    typedef struct packed {
        logic                    bounced_y;
        logic                    bounced_x;
        logic signed [VEL_W-1:0] vel_y;
        logic signed [VEL_W-1:0] vel_x;
        logic [POS_W-1:0]        pos_y;
        logic [POS_W-1:0]        pos_x;
        logic [IDX_W-1:0]        index;
    } result_t;

endpackage

@@ rtl/pwbs_ram.sv @@
module pwbs_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/pwbs_cfg.sv @@
module pwbs_cfg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pwbs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pwbs_pkg::CFG_DATA_W-1:0] cfg_data,
    output pwbs_pkg::cfg_t                  cfg
);

    pwbs_pkg::cfg_t cfg_reg;
    pwbs_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;

    // Decode the register index; drop writes beyond the list
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                pwbs_pkg::REG_AREA_WIDTH:
                    cfg_next.area_width = cfg_data[pwbs_pkg::AREA_W-1:0];
                pwbs_pkg::REG_AREA_HEIGHT:
                    cfg_next.area_height = cfg_data[pwbs_pkg::AREA_W-1:0];
                pwbs_pkg::REG_RADIUS:
                    cfg_next.radius = cfg_data[pwbs_pkg::RAD_W-1:0];
                pwbs_pkg::REG_TIME_STEP:
                    cfg_next.time_step = cfg_data[pwbs_pkg::DT_W-1:0];
                pwbs_pkg::REG_GRAVITY:
                    cfg_next.gravity = $signed(cfg_data[pwbs_pkg::VEL_W-1:0]);
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.area_width  <= pwbs_pkg::AREA_WIDTH_RST;
            cfg_reg.area_height <= pwbs_pkg::AREA_HEIGHT_RST;
            cfg_reg.radius      <= pwbs_pkg::RADIUS_RST;
            cfg_reg.time_step   <= pwbs_pkg::TIME_STEP_RST;
            cfg_reg.gravity     <= pwbs_pkg::GRAVITY_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/pwbs_core.sv @@
module pwbs_core #(
    parameter int unsigned MAX_PARTICLES = pwbs_pkg::MAX_PARTICLES_DEF,
    localparam int unsigned AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  pwbs_pkg::cfg_t                        cfg,
    // Item side
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  in_func,
    input  logic [pwbs_pkg::IDX_W-1:0]            in_index,
    input  logic [pwbs_pkg::POS_W-1:0]            in_pos_x,
    input  logic [pwbs_pkg::POS_W-1:0]            in_pos_y,
    input  logic signed [pwbs_pkg::VEL_W-1:0]     in_vel_x,
    input  logic signed [pwbs_pkg::VEL_W-1:0]     in_vel_y,
    // Result side
    output logic                                  res_valid,
    input  logic                                  res_ready,
    output pwbs_pkg::result_t                     res,
    // Particle memories
    output logic                                  ram_re,
    output logic [AW-1:0]                         ram_raddr,
    output logic                                  ram_we,
    output logic [AW-1:0]                         ram_waddr,
    output logic [pwbs_pkg::POS_MEM_W-1:0]        pos_wdata,
    output logic [pwbs_pkg::VEL_MEM_W-1:0]        vel_wdata,
    input  logic [pwbs_pkg::POS_MEM_W-1:0]        pos_rdata,
    input  logic [pwbs_pkg::VEL_MEM_W-1:0]        vel_rdata
);

    localparam int unsigned POS_W = pwbs_pkg::POS_W;
    localparam int unsigned VEL_W = pwbs_pkg::VEL_W;
    localparam int unsigned IDX_W = pwbs_pkg::IDX_W;
    localparam int unsigned PW    = 27;   // width of an unclamped position

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_WALL = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_MUL2 = 3'd3;
    localparam logic [2:0] ST_SUM  = 3'd4;
    localparam logic [2:0] ST_CLMP = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    // Negate a velocity, saturating the most negative value
    function automatic logic signed [VEL_W-1:0] neg_sat(input logic signed [VEL_W-1:0] v);
        logic signed [VEL_W-1:0] r;
        if (v == pwbs_pkg::VEL_MIN) begin
            r = pwbs_pkg::VEL_MAX;
        end else begin
            r = -v;
        end
        return r;
    endfunction

    // Saturate a 22-bit value to the velocity range
    function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [21:0] v);
        logic signed [VEL_W-1:0] r;
        if (v > 22'sd32767) begin
            r = pwbs_pkg::VEL_MAX;
        end else if (v < -22'sd32768) begin
            r = pwbs_pkg::VEL_MIN;
        end else begin
            r = v[VEL_W-1:0];
        end
        return r;
    endfunction

    // Clamp a position to [r, edge - r]; the low bound wins
    function automatic logic [POS_W-1:0] clamp_pos(input logic signed [PW-1:0] p,
                                                   input logic [15:0] rad,
                                                   input logic [POS_W-1:0] edge_q8);
        logic signed [PW:0]  p_plus_r;
        logic signed [19:0]  q;
        logic [POS_W-1:0]    r;
        p_plus_r = $signed({p[PW-1], p}) + $signed({12'd0, rad});
        q = $signed({1'b0, edge_q8}) - $signed({4'd0, rad});
        if (p <= $signed({11'd0, rad})) begin
            r = {3'd0, rad};
        end else if (p_plus_r >= $signed({9'd0, edge_q8})) begin
            r = q[19] ? '0 : q[POS_W-1:0];
        end else begin
            r = p[POS_W-1:0];
        end
        return r;
    endfunction

    logic [2:0] state_reg, state_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic wr_reg, wr_next;
    pwbs_pkg::result_t res_reg, res_next;

    // Pipeline work registers
    logic [POS_W-1:0]        px_reg, px_next, py_reg, py_next;
    logic signed [VEL_W-1:0] vx_reg, vx_next, vy_reg, vy_next;
    logic                    bx_reg, bx_next, by_reg, by_next;
    logic signed [28:0]      vxdt_reg, vxdt_next, vydt_reg, vydt_next, gdt_reg, gdt_next;
    logic signed [41:0]      gdt2_reg, gdt2_next;
    logic signed [21:0]      nx_reg, nx_next;
    logic signed [VEL_W-1:0] vyn_reg, vyn_next;
    logic signed [PW-1:0]    ny_reg, ny_next;

    logic [IDX_W+AW-1:0]     idx_wide;
    logic                    in_range;
    logic                    accept;
    logic [POS_W-1:0]        edge_w, edge_h;
    logic [POS_W-1:0]        rd_px, rd_py;
    logic signed [VEL_W-1:0] rd_vx, rd_vy;
    logic                    hit_x, hit_y;
    logic signed [12:0]      dt_s;
    logic signed [29:0]      nx_sum;
    logic signed [30:0]      vy_sum;
    logic signed [43:0]      ny_sum;

    assign idx_wide = {{AW{1'b0}}, in_index};
    assign in_range = (32'(in_index) < MAX_PARTICLES);
    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    assign edge_w = {cfg.area_width, 8'd0};
    assign edge_h = {cfg.area_height, 8'd0};
    assign dt_s   = $signed({1'b0, cfg.time_step});

    // Memory read on a step beat
    assign ram_re    = accept && (in_func == pwbs_pkg::FUNC_STEP) && in_range;
    assign ram_raddr = idx_wide[AW-1:0];

    // Write back as the result leaves
    assign res_valid = (state_reg == ST_OUT);
    assign res       = res_reg;
    assign ram_we    = res_valid && res_ready && wr_reg;
    assign ram_waddr = addr_reg;
    assign pos_wdata = {res_reg.pos_y, res_reg.pos_x};
    assign vel_wdata = {res_reg.vel_y, res_reg.vel_x};

    // Wall test on the entry read from memory
    assign rd_px = pos_rdata[POS_W-1:0];
    assign rd_py = pos_rdata[2*POS_W-1:POS_W];
    assign rd_vx = $signed(vel_rdata[VEL_W-1:0]);
    assign rd_vy = $signed(vel_rdata[2*VEL_W-1:VEL_W]);
    assign hit_x = ({1'b0, rd_px} + {4'd0, cfg.radius} >= {1'b0, edge_w})
                || (rd_px <= {3'd0, cfg.radius});
    assign hit_y = (rd_py <= {3'd0, cfg.radius})
                || ({1'b0, rd_py} + {4'd0, cfg.radius} >= {1'b0, edge_h});

    // Rounded sums: add half an LSB, keep the upper bits
    assign nx_sum = $signed({3'd0, px_reg, 8'd0}) + $signed({vxdt_reg[28], vxdt_reg})
                  + 30'sd128;
    assign vy_sum = $signed({{6{vy_reg[VEL_W-1]}}, vy_reg, 9'd0})
                  + $signed({{2{gdt_reg[28]}}, gdt_reg}) + 31'sd256;
    assign ny_sum = $signed({8'd0, py_reg, 17'd0})
                  - $signed({{6{vydt_reg[28]}}, vydt_reg, 9'd0})
                  - $signed({{2{gdt2_reg[41]}}, gdt2_reg}) + 44'sd65536;

    always_comb begin
        state_next = state_reg;
        addr_next  = addr_reg;
        wr_next    = wr_reg;
        res_next   = res_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        vx_next    = vx_reg;
        vy_next    = vy_reg;
        bx_next    = bx_reg;
        by_next    = by_reg;
        vxdt_next  = vxdt_reg;
        vydt_next  = vydt_reg;
        gdt_next   = gdt_reg;
        gdt2_next  = gdt2_reg;
        nx_next    = nx_reg;
        vyn_next   = vyn_reg;
        ny_next    = ny_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    addr_next       = idx_wide[AW-1:0];
                    res_next        = '0;
                    res_next.index  = in_index;
                    wr_next         = 1'b0;
                    if (!in_range) begin
                        state_next = ST_OUT;
                    end else if (in_func == pwbs_pkg::FUNC_LOAD) begin
                        res_next.pos_x = in_pos_x;
                        res_next.pos_y = in_pos_y;
                        res_next.vel_x = in_vel_x;
                        res_next.vel_y = in_vel_y;
                        wr_next        = 1'b1;
                        state_next     = ST_OUT;
                    end else begin
                        state_next = ST_WALL;
                    end
                end
            end
            ST_WALL: begin
                px_next    = rd_px;
                py_next    = rd_py;
                vx_next    = hit_x ? neg_sat(rd_vx) : rd_vx;
                vy_next    = hit_y ? neg_sat(rd_vy) : rd_vy;
                bx_next    = hit_x;
                by_next    = hit_y;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                vxdt_next  = vx_reg * dt_s;
                vydt_next  = vy_reg * dt_s;
                gdt_next   = cfg.gravity * dt_s;
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                gdt2_next  = gdt_reg * dt_s;
                nx_next    = nx_sum[29:8];
                vyn_next   = sat_vel(vy_sum[30:9]);
                state_next = ST_SUM;
            end
            ST_SUM: begin
                ny_next    = ny_sum[43:17];
                state_next = ST_CLMP;
            end
            ST_CLMP: begin
                res_next.pos_x     = clamp_pos({{(PW-22){nx_reg[21]}}, nx_reg},
                                               cfg.radius, edge_w);
                res_next.pos_y     = clamp_pos(ny_reg, cfg.radius, edge_h);
                res_next.vel_x     = vx_reg;
                res_next.vel_y     = vyn_reg;
                res_next.bounced_x = bx_reg;
                res_next.bounced_y = by_reg;
                wr_next            = 1'b1;
                state_next         = ST_OUT;
            end
            ST_OUT: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            wr_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            wr_reg    <= wr_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        addr_reg <= addr_next;
        res_reg  <= res_next;
        px_reg   <= px_next;
        py_reg   <= py_next;
        vx_reg   <= vx_next;
        vy_reg   <= vy_next;
        bx_reg   <= bx_next;
        by_reg   <= by_next;
        vxdt_reg <= vxdt_next;
        vydt_reg <= vydt_next;
        gdt_reg  <= gdt_next;
        gdt2_reg <= gdt2_next;
        nx_reg   <= nx_next;
        vyn_reg  <= vyn_next;
        ny_reg   <= ny_next;
    end

endmodule

@@ rtl/particle_wall_bounce_step.sv @@
// Particle store with an explicit Euler step and wall reflection. Each entry
// holds a Q11.8 position and a Q8.8 velocity in two registered-read memories.
// A load beat (tuser 0) writes an entry and answers with the loaded values; a
// step beat (tuser 1) reads the entry, reverses velocity components at the
// walls, moves the particle by one time step under gravity, clamps it inside
// the area and writes it back, answering with the new entry and bounce flags.
// One item is in flight at a time; an index beyond the store is answered with
// zeros and writes nothing. A load goes from acceptance straight to the output
// state; a step passes through the read, two multiplier stages, the wide y sum
// and the clamp. Each result reaches the output register with the write-back
// of the particle memories, and the input reopens in the cycle after the
// write-back, even while the previous result still waits in the output
// register; a stall of the result channel that outlasts the next item holds
// its write-back. Configuration writes are always taken and must only be
// issued while the block is idle.
module particle_wall_bounce_step #(
    parameter int unsigned MAX_PARTICLES = pwbs_pkg::MAX_PARTICLES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // particle_index[5:0], load_pos_x[24:6], load_pos_y[43:25],
    // load_vel_x[59:44], load_vel_y[75:60], zero[79:76]
    input  logic [79:0]                     s_tdata,
    // func[0]
    input  logic [0:0]                      s_tuser,
    // Result items
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // out_index[5:0], new_pos_x[24:6], new_pos_y[43:25],
    // new_vel_x[59:44], new_vel_y[75:60], zero[79:76]
    output logic [79:0]                     m_tdata,
    // bounced_x[0], bounced_y[1]
    output logic [1:0]                      m_tuser,
    // Configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pwbs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pwbs_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int unsigned AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;

    pwbs_pkg::cfg_t    cfg;
    pwbs_pkg::result_t res;
    logic              res_valid;
    logic              res_ready;

    logic                             ram_re;
    logic [AW-1:0]                    ram_raddr;
    logic                             ram_we;
    logic [AW-1:0]                    ram_waddr;
    logic [pwbs_pkg::POS_MEM_W-1:0]   pos_wdata, pos_rdata;
    logic [pwbs_pkg::VEL_MEM_W-1:0]   vel_wdata, vel_rdata;

    logic              out_valid_reg, out_valid_next;
    pwbs_pkg::result_t out_reg, out_next;

    pwbs_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pwbs_ram #(
        .WIDTH (pwbs_pkg::POS_MEM_W),
        .DEPTH (MAX_PARTICLES)
    ) u_pos_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (pos_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (pos_rdata)
    );

    pwbs_ram #(
        .WIDTH (pwbs_pkg::VEL_MEM_W),
        .DEPTH (MAX_PARTICLES)
    ) u_vel_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (vel_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (vel_rdata)
    );

    pwbs_core #(
        .MAX_PARTICLES (MAX_PARTICLES)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_func   (s_tuser[0]),
        .in_index  (s_tdata[5:0]),
        .in_pos_x  (s_tdata[24:6]),
        .in_pos_y  (s_tdata[43:25]),
        .in_vel_x  ($signed(s_tdata[59:44])),
        .in_vel_y  ($signed(s_tdata[75:60])),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .pos_wdata (pos_wdata),
        .vel_wdata (vel_wdata),
        .pos_rdata (pos_rdata),
        .vel_rdata (vel_rdata)
    );

    // Output register: take a new result when empty or draining
    assign res_ready = !out_valid_reg || m_tready;

    always_comb begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_ready) begin
            out_valid_next = res_valid;
            if (res_valid) begin
                out_next = res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_reg.vel_y, out_reg.vel_x, out_reg.pos_y,
                       out_reg.pos_x, out_reg.index};
    assign m_tuser  = {out_reg.bounced_y, out_reg.bounced_x};

    // The memories are never read and written in the same cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_we && ram_re))
        else $error("particle memory read and write overlap");

    // A write-back happens only as a result moves to the output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (res_valid && res_ready))
        else $error("write-back without result transfer");

    // An accepted item closes the input until its write-back
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while an item is in flight");

    // A result never enters a full, stalled output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |=> ($stable(m_tdata) && m_tvalid))
        else $error("stalled result overwritten");

endmodule

@@ tb/particle_wall_bounce_step_tb.sv @@
module particle_wall_bounce_step_tb;
    import pwbs_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned SETTLE_CYCLES = 12;
    localparam int unsigned PHASE_ITEMS   = 125;
    localparam int unsigned PHASES        = 8;
    localparam int unsigned MAX_POS       = 524287;
    // Register indexes that the block has no register for
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic                    func;
        logic [IDX_W-1:0]        idx;
        logic [POS_W-1:0]        pos_x;
        logic [POS_W-1:0]        pos_y;
        logic signed [VEL_W-1:0] vel_x;
        logic signed [VEL_W-1:0] vel_y;
    } particle_item_t;

    // Mirror of the particle store and registers; predicts every result beat
    class particle_tracker;
        logic [POS_W-1:0]        pos_x [MAX_PARTICLES_DEF];
        logic [POS_W-1:0]        pos_y [MAX_PARTICLES_DEF];
        logic signed [VEL_W-1:0] vel_x [MAX_PARTICLES_DEF];
        logic signed [VEL_W-1:0] vel_y [MAX_PARTICLES_DEF];
        logic [AREA_W-1:0]       area_w    = AREA_WIDTH_RST;
        logic [AREA_W-1:0]       area_h    = AREA_HEIGHT_RST;
        logic [RAD_W-1:0]        radius    = RADIUS_RST;
        logic [DT_W-1:0]         time_step = TIME_STEP_RST;
        logic signed [VEL_W-1:0] gravity   = GRAVITY_RST;
        result_t                 pending_results [$];
        int unsigned             errors = 0;

        function int unsigned pending();
            return pending_results.size();
        endfunction

        function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_AREA_WIDTH:  area_w    = data[AREA_W-1:0];
                REG_AREA_HEIGHT: area_h    = data[AREA_W-1:0];
                REG_RADIUS:      radius    = data[RAD_W-1:0];
                REG_TIME_STEP:   time_step = data[DT_W-1:0];
                REG_GRAVITY:     gravity   = data;
                default: ;
            endcase
        endfunction

        function longint sat_vel(longint v);
            if (v > VEL_MAX) return VEL_MAX;
            if (v < VEL_MIN) return VEL_MIN;
            return v;
        endfunction

        // Add half an LSB, then floor
        function longint round_shift(longint v, int unsigned sh);
            return (v + (longint'(1) << (sh - 1))) >>> sh;
        endfunction

        // Low bound wins; a negative high bound gives 0
        function longint clamp_coord(longint p, longint r, longint wall);
            if (p <= r) return r;
            if (p + r >= wall) return (wall - r < 0) ? 0 : wall - r;
            return p;
        endfunction

        function void note_item(logic [79:0] beat, logic func);
            logic [IDX_W-1:0] i;
            result_t res;
            longint px, py, vx, vy, rad, dt, g, w, h, nx, ny;
            i = beat[5:0];
            res = '0;
            res.index = i;
            if (func == FUNC_LOAD) begin
                pos_x[i] = beat[24:6];
                pos_y[i] = beat[43:25];
                vel_x[i] = beat[59:44];
                vel_y[i] = beat[75:60];
            end else begin
                px = pos_x[i];
                py = pos_y[i];
                vx = vel_x[i];
                vy = vel_y[i];
                rad = radius;
                dt = time_step;
                g = gravity;
                w = area_w;
                w = w * 256;
                h = area_h;
                h = h * 256;
                // reflect at the walls
                if (px + rad >= w || px <= rad) begin
                    vx = sat_vel(-vx);
                    res.bounced_x = 1'b1;
                end
                if (py <= rad || py + rad >= h) begin
                    vy = sat_vel(-vy);
                    res.bounced_y = 1'b1;
                end
                // Euler move; y falls by the half-g term too
                nx = round_shift(px * 256 + vx * dt, 8);
                ny = round_shift(py * 131072 - vy * dt * 512 - g * dt * dt, 17);
                vy = sat_vel(round_shift(vy * 512 + g * dt, 9));
                pos_x[i] = clamp_coord(nx, rad, w);
                pos_y[i] = clamp_coord(ny, rad, h);
                vel_x[i] = vx;
                vel_y[i] = vy;
            end
            res.pos_x = pos_x[i];
            res.pos_y = pos_y[i];
            res.vel_x = vel_x[i];
            res.vel_y = vel_y[i];
            pending_results.push_back(res);
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10) $display("[%0t] %s", $time, msg);
        endfunction

        function void compare(string name, longint want, longint got);
            if (want != got) flag($sformatf("mismatch %s: expected %0d, got %0d", name, want, got));
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_results.size() == 0) begin
                flag($sformatf("result beat for particle %0d with nothing pending", got.index));
                return;
            end
            want = pending_results.pop_front();
            compare("out_index", want.index, got.index);
            compare("new_pos_x", want.pos_x, got.pos_x);
            compare("new_pos_y", want.pos_y, got.pos_y);
            compare("new_vel_x", want.vel_x, got.vel_x);
            compare("new_vel_y", want.vel_y, got.vel_y);
            compare("bounced_x", want.bounced_x, got.bounced_x);
            compare("bounced_y", want.bounced_y, got.bounced_y);
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [79:0]           s_tdata   = '0;
    logic [0:0]            s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [79:0]           m_tdata;
    logic [1:0]            m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    particle_tracker tracker = new();
    int unsigned     gap_pct   = 0;
    int unsigned     stall_pct = 0;
    int unsigned     cycle_count = 0;
    int unsigned     cur_w = AREA_WIDTH_RST;
    int unsigned     cur_h = AREA_HEIGHT_RST;
    int unsigned     cur_r = RADIUS_RST;
    bit              ever_loaded [MAX_PARTICLES_DEF];

    particle_wall_bounce_step u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Stall the result channel at the phase's rate
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Watch all three channels; values read here are the ones sampled at the edge
    always @(posedge aclk) begin
        if (aresetn && cfg_valid && cfg_ready) tracker.apply_reg(cfg_index, cfg_data);
        if (aresetn && s_tvalid && s_tready) tracker.note_item(s_tdata, s_tuser[0]);
        if (aresetn && m_tvalid && m_tready) tracker.check_result(result_t'({m_tuser, m_tdata[75:0]}));
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic particle_item_t make_load(logic [IDX_W-1:0] i, logic [POS_W-1:0] px,
                                                 logic [POS_W-1:0] py, logic signed [VEL_W-1:0] vx,
                                                 logic signed [VEL_W-1:0] vy);
        particle_item_t it;
        it.func  = FUNC_LOAD;
        it.idx   = i;
        it.pos_x = px;
        it.pos_y = py;
        it.vel_x = vx;
        it.vel_y = vy;
        ever_loaded[i] = 1'b1;
        return it;
    endfunction

    // Load fields of a step beat carry noise the block must ignore
    function automatic particle_item_t make_step(logic [IDX_W-1:0] i);
        particle_item_t it;
        it.func  = FUNC_STEP;
        it.idx   = i;
        it.pos_x = $urandom();
        it.pos_y = $urandom();
        it.vel_x = $urandom();
        it.vel_y = $urandom();
        return it;
    endfunction

    // Mostly inside the area, some hugging a wall, some anywhere
    function automatic logic [POS_W-1:0] pick_coord(int unsigned wall_px);
        int c;
        case ($urandom_range(3))
            0: c = $urandom_range(0, MAX_POS);
            1: begin
                if ($urandom_range(1)) c = int'(wall_px * 256) - int'($urandom_range(0, 2 * cur_r));
                else c = $urandom_range(0, 2 * cur_r);
            end
            default: c = $urandom_range(0, wall_px * 256);
        endcase
        if (c < 0) c = 0;
        if (c > int'(MAX_POS)) c = MAX_POS;
        return c[POS_W-1:0];
    endfunction

    function automatic logic signed [VEL_W-1:0] pick_vel();
        int v;
        if ($urandom_range(1)) v = $urandom_range(0, 1023) - 512;
        else v = $urandom();
        return v[VEL_W-1:0];
    endfunction

    // Repeated steps on a few loaded particles follow whole trajectories
    function automatic particle_item_t random_item();
        logic [IDX_W-1:0] i;
        if ($urandom_range(1)) i = $urandom_range(0, 7);
        else i = $urandom_range(0, MAX_PARTICLES_DEF - 1);
        if ($urandom_range(9) < 3 || !ever_loaded[i])
            return make_load(i, pick_coord(cur_w), pick_coord(cur_h), pick_vel(), pick_vel());
        return make_step(i);
    endfunction

    task automatic send_item(particle_item_t it);
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.func;
        s_tdata  <= {4'b0, it.vel_y, it.vel_x, it.pos_y, it.pos_x, it.idx};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic issue_reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Upper data bits above the area and time-step register widths are noise
    task automatic program_area(logic [AREA_W-1:0] w, logic [AREA_W-1:0] h, logic [RAD_W-1:0] r,
                                logic [DT_W-1:0] dt, logic [VEL_W-1:0] g);
        issue_reg_write($urandom_range(REG_SPARE_LO, REG_SPARE_HI), $urandom());
        issue_reg_write(REG_AREA_WIDTH, {5'($urandom()), w});
        issue_reg_write(REG_AREA_HEIGHT, {5'($urandom()), h});
        issue_reg_write(REG_RADIUS, r);
        issue_reg_write(REG_TIME_STEP, {4'($urandom()), dt});
        issue_reg_write(REG_GRAVITY, g);
        cfg_valid <= 1'b0;
        cur_w = w;
        cur_h = h;
        cur_r = r;
    endtask

    // Hold input, drain every pending result, then let the pipeline empty
    task automatic settle();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        particle_item_t directed_items [$];
        int unsigned p, n;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed beats under the reset register values
        // both walls hit with minimum velocity: negation saturates
        directed_items.push_back(make_load(0, 0, 0, VEL_MIN, VEL_MIN));
        directed_items.push_back(make_step(0));
        // far corner with maximum position and velocity
        directed_items.push_back(make_load(1, MAX_POS, MAX_POS, VEL_MAX, VEL_MAX));
        directed_items.push_back(make_step(1));
        // mid-area falling at minimum velocity: vy saturates low
        directed_items.push_back(make_load(2, 102400, 102400, 0, VEL_MIN));
        directed_items.push_back(make_step(2));
        directed_items.push_back(make_load(3, 102400, 102400, VEL_MAX, VEL_MAX));
        directed_items.push_back(make_step(3));
        // inside the low wall and exactly on it: clamp to the radius
        directed_items.push_back(make_load(4, 1000, 1280, -300, 200));
        directed_items.push_back(make_step(4));
        directed_items.push_back(make_step(4));
        // right wall exactly, bottom wall just missed
        directed_items.push_back(make_load(5, 203520, 203519, 700, -700));
        directed_items.push_back(make_step(5));
        directed_items.push_back(make_step(5));
        directed_items.push_back(make_load(63, 51200, 150000, pick_vel(), pick_vel()));
        directed_items.push_back(make_step(63));
        directed_items.push_back(make_step(63));
        foreach (directed_items[k]) send_item(directed_items[k]);

        // Random phases, each with its own register set and idle pattern
        for (p = 0; p < PHASES; p++) begin
            settle();
            case (p)
                0: program_area(AREA_WIDTH_RST, AREA_HEIGHT_RST, RADIUS_RST, TIME_STEP_RST,
                                GRAVITY_RST);
                1: program_area(11'd2047, 11'd2047, 16'd0, 12'd4095, VEL_MAX);
                // radius beyond both edges, no time passing
                2: program_area(11'd1, 11'd1, 16'hFFFF, 12'd0, VEL_MIN);
                // small box: bounces on most steps
                3: program_area($urandom_range(8, 64), $urandom_range(8, 64),
                                $urandom_range(0, 1024), $urandom_range(64, 1024),
                                $urandom_range(0, 4000) - 3000);
                default: program_area($urandom_range(1) ? $urandom_range(1, 64)
                                                        : $urandom_range(1, 2047),
                                      $urandom_range(1) ? $urandom_range(1, 64)
                                                        : $urandom_range(1, 2047),
                                      $urandom_range(3) == 0 ? $urandom_range(0, 65535)
                                                             : $urandom_range(0, 4095),
                                      $urandom_range(0, 4095), $urandom());
            endcase
            case (p % 4)
                0: begin
                    gap_pct = 0;
                    stall_pct <= 0;
                end
                1: begin
                    gap_pct = 78;
                    stall_pct <= 0;
                end
                2: begin
                    gap_pct = 0;
                    stall_pct <= 78;
                end
                default: begin
                    gap_pct = 18;
                    stall_pct <= 18;
                end
            endcase
            for (n = 0; n < PHASE_ITEMS; n++) send_item(random_item());
        end

        settle();
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
